/* rtl/grc_pkg.sv */
// grc_pkg: widths, register indexes, reset values and shared structs
// for the gradient row color pipeline; no dependencies
package grc_pkg;

    localparam int ROW_W     = 12;
    localparam int CNT_W     = 3;
    localparam int CH_W      = 8;
    localparam int NUM_CH    = 3;
    localparam int RGB_W     = CH_W * NUM_CH;
    localparam int MAX_STOPS = 6;
    localparam int SEG_W     = 3;
    localparam int IDX_W     = 3;
    localparam int REG_W     = RGB_W;

    // blend dividend: (h-1)*(d+1) stays below h << CH_W
    localparam int NUM_W     = ROW_W + CH_W;

    // remainder pipeline: row mod span, bits per stage
    localparam int REM_STG   = 4;
    localparam int REM_STEPS = ROW_W / REM_STG;

    // blend quotient pipeline: quotient bits per stage
    localparam int DIV_STG   = 4;
    localparam int DIV_STEPS = CH_W / DIV_STG;

    // blend stages: prep, product, quotient stages, output
    localparam int BL_STG    = DIV_STG + 3;

    // reciprocal constants for h/3 and h/5 (exact for 12-bit h)
    localparam int RECIP3    = 2731;
    localparam int SHIFT3    = 13;
    localparam int RECIP5    = 3277;
    localparam int SHIFT5    = 14;
    localparam int PROD_W    = SHIFT5 + ROW_W;

    localparam logic [ROW_W-1:0] HEIGHT_RST = ROW_W'(256);
    localparam logic [CNT_W-1:0] COUNT_RST  = CNT_W'(2);
    localparam logic [RGB_W-1:0] COLOR0_RST = '0;
    localparam logic [RGB_W-1:0] COLOR1_RST = '1;

    typedef enum logic [IDX_W-1:0] {
        REG_HEIGHT = 3'd0,
        REG_COUNT  = 3'd1,
        REG_COLOR0 = 3'd2,
        REG_COLOR1 = 3'd3,
        REG_COLOR2 = 3'd4,
        REG_COLOR3 = 3'd5,
        REG_COLOR4 = 3'd6,
        REG_COLOR5 = 3'd7
    } t_reg_idx;

    // effective configuration seen by every stage
    typedef struct packed {
        logic [ROW_W-1:0]                  height;
        logic [CNT_W-1:0]                  n;
        logic [ROW_W-1:0]                  span;
        logic [MAX_STOPS-1:0][RGB_W-1:0]   color;
    } t_cfg;

    // front stage to remainder pipeline
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [RGB_W-1:0] a;
        logic [RGB_W-1:0] b;
        logic             zspan;
    } t_front;

    // remainder pipeline to blend pipeline
    typedef struct packed {
        logic [ROW_W-1:0] m;
        logic [RGB_W-1:0] a;
        logic [RGB_W-1:0] b;
    } t_mid;

endpackage

/* rtl/grc_front.sv */
// grc_front: row clamp, segment pick and stop color select, one stage
// depends on grc_pkg
module grc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  grc_pkg::t_cfg        i_cfg,
    input  logic                 i_valid,
    input  logic [11:0]          i_row_index,
    output logic                 o_ready,
    output logic                 o_valid,
    output grc_pkg::t_front      o_data,
    input  logic                 i_ready
);
    import grc_pkg::*;

    logic [ROW_W-1:0]       row_c;
    logic [ROW_W+CNT_W-1:0] nrow;
    logic [SEG_W-1:0]       seg;
    logic [SEG_W-1:0]       seg_hi;
    t_front                 n_data;
    logic                   r_v;
    t_front                 r_data;

    // clamp row and count segment boundaries at or below n*row
    always_comb begin
        row_c = (i_row_index >= i_cfg.height) ? i_cfg.height - ROW_W'(1) : i_row_index;
        nrow  = (ROW_W+CNT_W)'(row_c) * (ROW_W+CNT_W)'(i_cfg.n);
        seg   = '0;
        for (int k = 1; k < MAX_STOPS - 1; k++) begin
            if ((CNT_W'(k) < i_cfg.n) &&
                ((ROW_W+CNT_W)'(i_cfg.height) * (ROW_W+CNT_W)'(k) <= nrow)) begin
                seg = seg + SEG_W'(1);
            end
        end
        seg_hi       = seg + SEG_W'(1);
        n_data.row   = row_c;
        n_data.a     = i_cfg.color[seg];
        n_data.b     = i_cfg.color[seg_hi];
        n_data.zspan = (i_cfg.span == '0);
    end

    assign o_ready = !r_v || i_ready;

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_v;
    assign o_data  = r_data;

endmodule

/* rtl/grc_rem.sv */
// grc_rem: pipelined restoring remainder, row mod span, a few bits per stage
// depends on grc_pkg
module grc_rem (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  grc_pkg::t_cfg        i_cfg,
    input  logic                 i_valid,
    input  grc_pkg::t_front      i_data,
    output logic                 o_ready,
    output logic                 o_valid,
    output grc_pkg::t_mid        o_data,
    input  logic                 i_ready
);
    import grc_pkg::*;

    typedef struct packed {
        logic [ROW_W-1:0] row_sh;
        logic [ROW_W-1:0] rem;
        logic [RGB_W-1:0] a;
        logic [RGB_W-1:0] b;
        logic             zspan;
    } t_rem_st;

    t_rem_st            r_st [REM_STG];
    t_rem_st            n_st [REM_STG];
    logic [REM_STG-1:0] r_v;
    logic [REM_STG:0]   rdy;
    logic [REM_STG-1:0] in_v;

    // one restoring step: shift in next row bit, subtract span if it fits
    function automatic t_rem_st rem_step(input t_rem_st x, input logic [ROW_W-1:0] span);
        t_rem_st        y;
        logic [ROW_W:0] t;
        y = x;
        t = {x.rem, x.row_sh[ROW_W-1]};
        if (t >= {1'b0, span}) begin
            t = t - {1'b0, span};
        end
        y.rem    = t[ROW_W-1:0];
        y.row_sh = {x.row_sh[ROW_W-2:0], 1'b0};
        return y;
    endfunction

    // next value of every stage
    always_comb begin
        t_rem_st cur;
        for (int j = 0; j < REM_STG; j++) begin
            if (j == 0) begin
                cur.row_sh = i_data.row;
                cur.rem    = '0;
                cur.a      = i_data.a;
                cur.b      = i_data.b;
                cur.zspan  = i_data.zspan;
            end else begin
                cur = r_st[j-1];
            end
            for (int s = 0; s < REM_STEPS; s++) begin
                cur = rem_step(cur, i_cfg.span);
            end
            n_st[j] = cur;
        end
    end

    // per-stage ready so bubbles close up under a stall
    always_comb begin
        rdy[REM_STG] = i_ready;
        for (int j = REM_STG - 1; j >= 0; j--) begin
            rdy[j] = !r_v[j] || rdy[j+1];
        end
        for (int j = 0; j < REM_STG; j++) begin
            in_v[j] = (j == 0) ? i_valid : r_v[j-1];
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < REM_STG; j++) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (rdy[j]) begin
                r_v[j] <= in_v[j];
            end
            if (rdy[j] && in_v[j]) begin
                r_st[j] <= n_st[j];
            end
        end
    end

    // zero span means position zero inside the segment
    assign o_ready  = rdy[0];
    assign o_valid  = r_v[REM_STG-1];
    assign o_data.m = r_st[REM_STG-1].zspan ? '0 : r_st[REM_STG-1].rem;
    assign o_data.a = r_st[REM_STG-1].a;
    assign o_data.b = r_st[REM_STG-1].b;

endmodule

/* rtl/grc_blend.sv */
// grc_blend: per-channel product, pipelined quotient by height and final
// add or subtract into the output register; depends on grc_pkg
module grc_blend (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  grc_pkg::t_cfg        i_cfg,
    input  logic                 i_valid,
    input  grc_pkg::t_mid        i_data,
    output logic                 o_ready,
    output logic                 o_valid,
    output logic [7:0]           o_red,
    output logic [7:0]           o_green,
    output logic [7:0]           o_blue,
    input  logic                 i_ready
);
    import grc_pkg::*;

    typedef struct packed {
        logic [CH_W-1:0]  c0;
        logic             fall;
        logic [NUM_W-1:0] rem;
        logic [CH_W-1:0]  q;
    } t_dch;

    logic [BL_STG-1:0] r_v;
    logic [BL_STG:0]   rdy;
    logic [BL_STG-1:0] in_v;

    logic [ROW_W-1:0]  r_mn;
    logic [CH_W-1:0]   r_c0   [NUM_CH];
    logic [CH_W-1:0]   r_d    [NUM_CH];
    logic              r_fall [NUM_CH];
    logic [ROW_W-1:0]  n_mn;
    logic [CH_W-1:0]   n_c0   [NUM_CH];
    logic [CH_W-1:0]   n_d    [NUM_CH];
    logic              n_fall [NUM_CH];

    t_dch              r_ch [DIV_STG+1][NUM_CH];
    t_dch              n_ch [DIV_STG+1][NUM_CH];

    logic [CH_W-1:0]   r_out [NUM_CH];
    logic [CH_W-1:0]   n_out [NUM_CH];

    // one quotient bit: subtract h << bit position when it fits
    function automatic t_dch div_step(input t_dch x, input logic [ROW_W-1:0] h,
                                      input int bitpos);
        t_dch             y;
        logic [NUM_W-1:0] dv;
        logic             hit;
        y   = x;
        dv  = NUM_W'(h) << bitpos;
        hit = (x.rem >= dv);
        if (hit) begin
            y.rem = x.rem - dv;
        end
        y.q = {x.q[CH_W-2:0], hit};
        return y;
    endfunction

    // prep: m*n, channel difference and direction
    always_comb begin
        logic [CH_W-1:0] ca;
        logic [CH_W-1:0] cb;
        n_mn = ROW_W'(i_data.m * i_cfg.n);
        for (int c = 0; c < NUM_CH; c++) begin
            ca        = i_data.a[RGB_W-1-c*CH_W -: CH_W];
            cb        = i_data.b[RGB_W-1-c*CH_W -: CH_W];
            n_c0[c]   = ca;
            n_fall[c] = !(ca < cb);
            n_d[c]    = (ca < cb) ? cb - ca : ca - cb;
        end
    end

    // product stage and quotient stages
    always_comb begin
        t_dch cur;
        for (int c = 0; c < NUM_CH; c++) begin
            n_ch[0][c].c0   = r_c0[c];
            n_ch[0][c].fall = r_fall[c];
            n_ch[0][c].q    = '0;
            // falling channels round the quotient up
            n_ch[0][c].rem  = NUM_W'(r_mn) * NUM_W'(r_d[c]) +
                              (r_fall[c] ? NUM_W'(i_cfg.height - ROW_W'(1)) : '0);
            for (int d = 0; d < DIV_STG; d++) begin
                cur = r_ch[d][c];
                for (int s = 0; s < DIV_STEPS; s++) begin
                    cur = div_step(cur, i_cfg.height, CH_W - 1 - d*DIV_STEPS - s);
                end
                n_ch[d+1][c] = cur;
            end
            n_out[c] = r_ch[DIV_STG][c].fall ? r_ch[DIV_STG][c].c0 - r_ch[DIV_STG][c].q
                                             : r_ch[DIV_STG][c].c0 + r_ch[DIV_STG][c].q;
        end
    end

    // per-stage ready so bubbles close up under a stall
    always_comb begin
        rdy[BL_STG] = i_ready;
        for (int j = BL_STG - 1; j >= 0; j--) begin
            rdy[j] = !r_v[j] || rdy[j+1];
        end
        for (int j = 0; j < BL_STG; j++) begin
            in_v[j] = (j == 0) ? i_valid : r_v[j-1];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < BL_STG; j++) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (rdy[j]) begin
                r_v[j] <= in_v[j];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (rdy[0] && in_v[0]) begin
            r_mn <= n_mn;
            for (int c = 0; c < NUM_CH; c++) begin
                r_c0[c]   <= n_c0[c];
                r_d[c]    <= n_d[c];
                r_fall[c] <= n_fall[c];
            end
        end
        for (int d = 0; d <= DIV_STG; d++) begin
            if (rdy[d+1] && in_v[d+1]) begin
                for (int c = 0; c < NUM_CH; c++) begin
                    r_ch[d][c] <= n_ch[d][c];
                end
            end
        end
        if (rdy[BL_STG-1] && in_v[BL_STG-1]) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_out[c] <= n_out[c];
            end
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_v[BL_STG-1];
    assign o_red   = r_out[0];
    assign o_green = r_out[1];
    assign o_blue  = r_out[2];

endmodule

/* rtl/gradient_row_color.sv */
// gradient_row_color: 1 front stage, 4 remainder stages, 7 blend stages;
// one beat per cycle sustained while i_ready is high, set by the fully
// pipelined remainder and quotient dividers.
// Synchronous active-low reset clears all valid bits and loads the
// configuration registers with their reset values.
// Config registers and derived settings; depends on grc_pkg and the stages
module gradient_row_color (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [11:0] i_row_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue
);
    import grc_pkg::*;

    logic [ROW_W-1:0]                r_height;
    logic [CNT_W-1:0]                r_count;
    logic [MAX_STOPS-1:0][RGB_W-1:0] r_color;

    logic [CNT_W-1:0]  cnt;
    logic [PROD_W-1:0] p3;
    logic [PROD_W-1:0] p5;
    t_cfg              cfg;

    logic   f_valid;
    logic   f_ready;
    t_front f_data;
    logic   m_valid;
    logic   m_ready;
    t_mid   m_data;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= HEIGHT_RST;
            r_count  <= COUNT_RST;
            r_color  <= {{((MAX_STOPS-2)*RGB_W){1'b0}}, COLOR1_RST, COLOR0_RST};
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_HEIGHT: begin
                    r_height <= i_cfg_data[ROW_W-1:0];
                end
                REG_COUNT: begin
                    r_count <= i_cfg_data[CNT_W-1:0];
                end
                REG_COLOR0, REG_COLOR1, REG_COLOR2,
                REG_COLOR3, REG_COLOR4, REG_COLOR5: begin
                    r_color[SEG_W'(i_cfg_idx - REG_COLOR0)] <= i_cfg_data[RGB_W-1:0];
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    // effective height, segment count and span h/n
    always_comb begin
        cnt = r_count;
        if (cnt < CNT_W'(2)) begin
            cnt = CNT_W'(2);
        end
        if (cnt > CNT_W'(MAX_STOPS)) begin
            cnt = CNT_W'(MAX_STOPS);
        end
        cfg.height = (r_height == '0) ? ROW_W'(1) : r_height;
        cfg.n      = cnt - CNT_W'(1);
        cfg.color  = r_color;
        p3 = PROD_W'(cfg.height) * PROD_W'(RECIP3);
        p5 = PROD_W'(cfg.height) * PROD_W'(RECIP5);
        case (cfg.n)
            3'd2:    cfg.span = {1'b0, cfg.height[ROW_W-1:1]};
            3'd3:    cfg.span = p3[SHIFT3 +: ROW_W];
            3'd4:    cfg.span = {2'b00, cfg.height[ROW_W-1:2]};
            3'd5:    cfg.span = p5[SHIFT5 +: ROW_W];
            default: cfg.span = cfg.height;
        endcase
    end

    grc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (i_valid),
        .i_row_index (i_row_index),
        .o_ready     (o_ready),
        .o_valid     (f_valid),
        .o_data      (f_data),
        .i_ready     (f_ready)
    );

    grc_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (f_valid),
        .i_data  (f_data),
        .o_ready (f_ready),
        .o_valid (m_valid),
        .o_data  (m_data),
        .i_ready (m_ready)
    );

    grc_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (m_valid),
        .i_data  (m_data),
        .o_ready (m_ready),
        .o_valid (o_valid),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue),
        .i_ready (i_ready)
    );

endmodule
